/* design/ggc_pkg.sv */
// Shared types and constants for the go-to-goal controller.
package ggc_pkg;

  localparam int unsigned CordicIter = 16;
  localparam int unsigned IterW      = 5;
  localparam int unsigned CordW      = 40;
  localparam int unsigned ZW         = 24;
  localparam int unsigned SqW        = 34;

  localparam logic [ZW-1:0] HalfPiQ20 = 24'd1647099;

  localparam logic [15:0] GoalReset  = 16'd5120;
  localparam logic [16:0] TolReset   = 17'd102;
  localparam logic [14:0] TurnReset  = 15'd819;

  localparam logic CfgTolerance = 1'b0;
  localparam logic CfgTurn      = 1'b1;

  localparam logic [1:0] ModeRotate  = 2'd0;
  localparam logic [1:0] ModeForward = 2'd1;
  localparam logic [1:0] ModeStop    = 2'd2;

  // Start request to the shared arithmetic unit
  typedef struct packed {
    logic               start;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } ggc_req_t;

  // Result of the shared arithmetic unit
  typedef struct packed {
    logic               done;
    logic signed [15:0] bearing;
    logic [16:0]        distance;
  } ggc_rsp_t;

  // atan(2^-i) in Q20 radians, rounded to nearest
  function automatic logic [ZW-1:0] atan_q20(input logic [IterW-1:0] i);
    logic [ZW-1:0] r;
    begin
      case (i)
        5'd0:  r = 24'd823550;
        5'd1:  r = 24'd486170;
        5'd2:  r = 24'd256879;
        5'd3:  r = 24'd130396;
        5'd4:  r = 24'd65451;
        5'd5:  r = 24'd32757;
        5'd6:  r = 24'd16383;
        5'd7:  r = 24'd8192;
        5'd8:  r = 24'd4096;
        5'd9:  r = 24'd2048;
        5'd10: r = 24'd1024;
        5'd11: r = 24'd512;
        5'd12: r = 24'd256;
        5'd13: r = 24'd128;
        5'd14: r = 24'd64;
        5'd15: r = 24'd32;
        5'd16: r = 24'd16;
        5'd17: r = 24'd8;
        5'd18: r = 24'd4;
        5'd19: r = 24'd2;
        5'd20: r = 24'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/ggc_arith.sv */
// Shared iterative unit: CORDIC vectoring for the bearing, then bit-pair square root.
module ggc_arith (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ggc_pkg::ggc_req_t req_i,
  output ggc_pkg::ggc_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCordic,
    StSqrt
  } state_e;

  state_e state_q;
  logic [ggc_pkg::IterW-1:0] cnt_q;
  logic signed [ggc_pkg::CordW-1:0] x_q, y_q;
  logic signed [ggc_pkg::ZW-1:0] z_q;
  logic zero_q;
  logic [ggc_pkg::SqW-1:0] rem_q;
  logic [ggc_pkg::SqW-1:0] root_q;
  logic [ggc_pkg::SqW-1:0] bit_q;
  logic done_q;
  logic signed [15:0] bearing_q;

  // Prerotated start vector, with the per-step CORDIC and square root terms
  logic signed [ggc_pkg::CordW-1:0] x0, y0, xs, ys;
  logic signed [ggc_pkg::ZW-1:0] z0, zr;
  logic [ggc_pkg::SqW-1:0] sq0, trial;
  logic signed [ggc_pkg::ZW-1:0] ang;

  always_comb begin
    x0 = ggc_pkg::CordW'(req_i.dx) <<< 20;
    y0 = ggc_pkg::CordW'(req_i.dy) <<< 20;
    z0 = '0;
    if (req_i.dx < 0) begin
      if (req_i.dy >= 0) begin
        x0 = ggc_pkg::CordW'(req_i.dy) <<< 20;
        y0 = -(ggc_pkg::CordW'(req_i.dx) <<< 20);
        z0 = ggc_pkg::HalfPiQ20;
      end else begin
        x0 = -(ggc_pkg::CordW'(req_i.dy) <<< 20);
        y0 = ggc_pkg::CordW'(req_i.dx) <<< 20;
        z0 = -ggc_pkg::HalfPiQ20;
      end
    end
    sq0 = ggc_pkg::SqW'($unsigned(34'(req_i.dx * req_i.dx)))
        + ggc_pkg::SqW'($unsigned(34'(req_i.dy * req_i.dy)));
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    ang = ggc_pkg::ZW'(ggc_pkg::atan_q20(cnt_q));
    trial = root_q + bit_q;
    zr = z_q + ggc_pkg::ZW'(128);
  end

  // Sequence CORDIC steps then square root steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req_i.start) begin
            x_q <= x0;
            y_q <= y0;
            z_q <= z0;
            zero_q <= (req_i.dx == 0) && (req_i.dy == 0);
            rem_q <= sq0;
            root_q <= '0;
            bit_q <= ggc_pkg::SqW'(1) << (ggc_pkg::SqW - 2);
            cnt_q <= '0;
            state_q <= StCordic;
          end
        end
        StCordic: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + ang;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - ang;
          end
          if (cnt_q == ggc_pkg::IterW'(ggc_pkg::CordicIter - 1)) begin
            state_q <= StSqrt;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        StSqrt: begin
          if (rem_q >= trial) begin
            rem_q <= rem_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == ggc_pkg::SqW'(1)) begin
            bearing_q <= zero_q ? '0 : 16'(zr >>> 8);
            done_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bearing = bearing_q;
  assign rsp_o.distance = root_q[16:0];

endmodule

/* design/go_to_goal_controller_unit.sv */
// Top level of the go-to-goal controller: goal state, sequencing and result register.
// A target item is taken and gives no result. A pose item while moving takes
// 16 CORDIC steps and 17 square root steps in one shared unit before the result is
// offered; input is not ready until the result has been taken and is ready again
// the cycle after, so a new pose is not taken while the last is still in work.
// A pose item while not moving is dropped. No clearing pass after reset.
module go_to_goal_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // pos_x[15:0], pos_y[31:16], heading[46:32]
  input  logic         s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dx to goal, dy to goal, heading_error, distance, arrival flag, drive_mode,
  // linear_velocity, angular_velocity from bit 0 up; zero filled to 136 bits
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StBusy,
    StOut
  } state_e;

  state_e state_q;
  logic [15:0] goal_x_q, goal_y_q;
  logic moving_q;
  logic [16:0] tol_q;
  logic [14:0] turn_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [14:0] hd_q;
  logic [135:0] out_q;
  logic start_q;
  ggc_pkg::ggc_req_t req;
  ggc_pkg::ggc_rsp_t rsp;

  logic signed [15:0] px, py;
  logic signed [16:0] err, aerr;
  logic at;
  logic [1:0] mode;
  logic [16:0] lin;
  logic signed [15:0] angv;

  assign px = s_axis_tdata[15:0];
  assign py = s_axis_tdata[31:16];
  assign s_axis_tready = (state_q == StIdle);

  assign req.start = start_q;
  assign req.dx = dx_q;
  assign req.dy = dy_q;

  ggc_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Decide the drive command from the finished bearing and distance
  always_comb begin
    err = 17'(rsp.bearing) - 17'(hd_q);
    aerr = (err < 0) ? -err : err;
    lin = '0;
    angv = err[15:0];
    at = 1'b0;
    if (rsp.distance <= tol_q) begin
      at = 1'b1;
      mode = ggc_pkg::ModeStop;
      angv = '0;
    end else if (aerr > 17'(turn_q)) begin
      mode = ggc_pkg::ModeRotate;
    end else begin
      mode = ggc_pkg::ModeForward;
      lin = rsp.distance;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ggc_pkg::TolReset;
      turn_q <= ggc_pkg::TurnReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ggc_pkg::CfgTolerance: tol_q <= cfg_data_i;
        ggc_pkg::CfgTurn:      turn_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Sequence items and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      goal_x_q <= ggc_pkg::GoalReset;
      goal_y_q <= ggc_pkg::GoalReset;
      moving_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              goal_x_q <= px;
              goal_y_q <= py;
              moving_q <= 1'b1;
            end else if (moving_q) begin
              dx_q <= 17'($signed(goal_x_q)) - 17'(px);
              dy_q <= 17'($signed(goal_y_q)) - 17'(py);
              hd_q <= s_axis_tdata[46:32];
              start_q <= 1'b1;
              state_q <= StBusy;
            end
          end
        end
        StBusy: begin
          if (rsp.done) begin
            out_q <= {33'd0, angv, lin, mode, at, rsp.distance, err[15:0], dy_q, dx_q};
            if (at) begin
              moving_q <= 1'b0;
            end
            state_q <= StOut;
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = out_q;

  // A stop result always carries zero velocities
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[69:68] == ggc_pkg::ModeStop)
      |-> (m_axis_tdata[102:70] == '0))
    else $error("stop result with nonzero velocity");

  // Arithmetic unit finishes only while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == StBusy))
    else $error("unexpected arithmetic completion");

  // An arrival clears the moving flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) && rsp.done && at |=> !moving_q)
    else $error("moving flag kept after arrival");

endmodule

/* bench/tb_go_to_goal_controller_unit.sv */
// Self-checking testbench for the go-to-goal controller unit.
`timescale 1ns / 100ps

module tb_go_to_goal_controller_unit;

  localparam int HalfPeriod = 6;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  // One steering result, field by field
  typedef struct packed {
    logic signed [16:0] x_off;
    logic signed [16:0] y_off;
    logic signed [15:0] head_err;
    logic [16:0]        distance;
    logic               at_goal;
    logic [1:0]         mode;
    logic [16:0]        lin_vel;
    logic signed [15:0] ang_vel;
  } steer_t;

  localparam longint AtanQ20 [16] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                      16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                      64, 32};

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [16:0]  cfg_data_i = '0;

  // Predictor state
  logic signed [15:0] goal_x, goal_y;
  logic               moving;
  logic [16:0]        tol_q10;
  logic [14:0]        turn_q12;

  steer_t steer_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;
  bit     rx_hold = 1'b0;
  int     rx_wait = 0;

  go_to_goal_controller_unit dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  // Bearing to the goal from a CORDIC atan2 in vectoring mode, Q12 radians
  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 1048576;
    y = dy * 1048576;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ggc_pkg::HalfPiQ20;
      end else begin
        x = -y; y = t; z = -longint'(ggc_pkg::HalfPiQ20);
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + AtanQ20[i];
      end else begin
        x = x - ys; y = y + xs; z = z - AtanQ20[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Advance the predictor by one item; push a steering result when one is due
  task automatic predict_steer(input logic func, input logic [15:0] px, input logic [15:0] py,
                               input logic [14:0] hd);
    longint dx, dy, err, aerr, d_len;
    steer_t s;
    if (!func) begin
      goal_x = px;
      goal_y = py;
      moving = 1'b1;
    end else if (moving) begin
      dx = longint'(goal_x) - longint'($signed(px));
      dy = longint'(goal_y) - longint'($signed(py));
      d_len = floor_sqrt(dx * dx + dy * dy);
      err = bearing_q12(dx, dy) - longint'($signed(hd));
      aerr = err < 0 ? -err : err;
      s = '0;
      s.x_off = 17'(dx);
      s.y_off = 17'(dy);
      s.head_err = 16'(err);
      s.distance = 17'(d_len);
      if (d_len <= tol_q10) begin
        s.at_goal = 1'b1;
        s.mode = ggc_pkg::ModeStop;
        moving = 1'b0;
      end else if (aerr > turn_q12) begin
        s.mode = ggc_pkg::ModeRotate;
        s.ang_vel = 16'(err);
      end else begin
        s.mode = ggc_pkg::ModeForward;
        s.lin_vel = 17'(d_len);
        s.ang_vel = 16'(err);
      end
      steer_q.push_back(s);
    end
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic func, input logic [15:0] px, input logic [15:0] py,
                           input logic [14:0] hd);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {1'b0, hd, py, px};
    s_axis_tuser = func;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_steer(func, px, py, hd);
  endtask

  // Stop sending and let every expected result drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == ggc_pkg::CfgTolerance) tol_q10 = val;
    else turn_q12 = val[14:0];
  endtask

  // Heading that points near the goal, so forward driving shows up
  function automatic logic [14:0] aimed_heading(input logic [15:0] px, input logic [15:0] py,
                                                input int spread);
    longint b;
    b = bearing_q12(longint'(goal_x) - longint'($signed(px)),
                    longint'(goal_y) - longint'($signed(py)));
    return 15'(b + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // One route: a target, then poses around it, often ending at the goal
  task automatic run_route(input int poses);
    logic [15:0] tx, ty, px, py;
    int r, span;
    tx = 16'($urandom);
    ty = 16'($urandom);
    send_item(1'b0, tx, ty, 15'($urandom));
    for (int i = 0; i < poses; i++) begin
      r = $urandom_range(0, 9);
      span = (r < 2) ? 60 : (r < 6) ? 3000 : (r < 8) ? 200 : 32767;
      if (i == poses - 1 && $urandom_range(0, 1)) span = 0;
      px = tx + 16'($signed($urandom_range(0, 2 * span)) - span);
      py = ty + 16'($signed($urandom_range(0, 2 * span)) - span);
      if ($urandom_range(0, 2) == 0) send_item(1'b1, px, py, 15'($urandom));
      else send_item(1'b1, px, py, aimed_heading(px, py, 400));
    end
  endtask

  // Receiver stalls: per-result random wait, or a long hold
  always @(negedge clk_i) begin
    if (rx_hold) begin
      m_axis_tready = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    steer_t got, exp_s;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tdata[49:34],
             m_axis_tdata[66:50], m_axis_tdata[67], m_axis_tdata[69:68],
             m_axis_tdata[86:70], m_axis_tdata[102:87]};
      rx_wait = rx_idle_en ? $urandom_range(0, 19) : 0;
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_s = steer_q.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp xo=%0d yo=%0d he=%0d d=%0d at=%0d m=%0d lv=%0d av=%0d",
                      " | got xo=%0d yo=%0d he=%0d d=%0d at=%0d m=%0d lv=%0d av=%0d"},
                     exp_s.x_off, exp_s.y_off, exp_s.head_err, exp_s.distance,
                     exp_s.at_goal, exp_s.mode, exp_s.lin_vel, exp_s.ang_vel, got.x_off,
                     got.y_off, got.head_err, got.distance, got.at_goal, got.mode,
                     got.lin_vel, got.ang_vel);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_go_to_goal_controller_unit: errors");
      $finish;
    end
  end

  // Extremes, both special bearings, idle poses and each drive mode
  task automatic test_directed();
    send_item(1'b1, 16'd0, 16'd0, 15'd0);                   // idle pose, dropped
    send_item(1'b1, 16'h8000, 16'h7FFF, 15'h3FFF);          // still idle, default goal
    send_item(1'b0, 16'h7FFF, 16'h7FFF, 15'h4000);
    send_item(1'b1, 16'h8000, 16'h8000, 15'h4000);          // largest offset
    send_item(1'b1, 16'h7FFF, 16'h7FFF, 15'h7FFF);          // zero offset, stop
    send_item(1'b1, 16'h1234, 16'h0000, 15'h0000);          // idle again
    send_item(1'b0, 16'h8000, 16'h8000, 15'h0000);
    send_item(1'b1, 16'h7FFF, 16'h7FFF, 15'h3FFF);          // most negative offset
    send_item(1'b1, 16'h0000, 16'h8000, 15'h4000);          // goal straight behind
    send_item(1'b1, 16'h8000, 16'h0000, 15'h0000);
    send_item(1'b0, 16'd1000, 16'd1000, 15'd0);
    send_item(1'b1, 16'd0, 16'd1000, 15'd0);                // ahead, forward
    send_item(1'b1, 16'd0, 16'd0, 15'd3217);                // near pi/4, forward
    send_item(1'b1, 16'd0, 16'd1000, 15'h7000);             // rotate only
    send_item(1'b1, 16'd1100, 16'd1000, 15'd0);             // straight behind, within tolerance, stop
    send_item(1'b1, 16'd1050, 16'd1050, 15'd0);             // idle after arrival, dropped
    wait_idle();
  endtask

  // Walk both registers through their extremes
  task automatic test_config_sweep();
    logic [16:0] tols [4];
    logic [16:0] turns [4];
    tols = '{17'd0, 17'd92682, 17'h1FFFF, 17'd500};
    turns = '{17'd0, 17'd25736, 17'h7FFF, 17'd100};
    for (int k = 0; k < 4; k++) begin
      write_reg(ggc_pkg::CfgTolerance, tols[k]);
      write_reg(ggc_pkg::CfgTurn, turns[k]);
      for (int j = 0; j < 4; j++) run_route($urandom_range(1, 4));
      wait_idle();
    end
    write_reg(ggc_pkg::CfgTolerance, ggc_pkg::TolReset);
    write_reg(ggc_pkg::CfgTurn, 17'(ggc_pkg::TurnReset));
  endtask

  // Mostly routes, some stray items; phases with no idling on either side
  task automatic test_random(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        run_route(n);
        sent += n + 1;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (500) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      run_route(5);
    join
    wait_idle();
  endtask

  initial begin
    goal_x = ggc_pkg::GoalReset;
    goal_y = ggc_pkg::GoalReset;
    moving = 1'b0;
    tol_q10 = ggc_pkg::TolReset;
    turn_q12 = ggc_pkg::TurnReset;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(180);
    wait_idle();
    test_random(180);
    wait_idle();

    if (mismatches == 0 && steer_q.size() == 0) begin
      $display("tb_go_to_goal_controller_unit: clean");
    end else begin
      $display("tb_go_to_goal_controller_unit: errors");
    end
    $finish;
  end

endmodule
